>>> src/xxh_pkg.sv
// ----------------------------------------------------------------------------
// xxh_pkg
// shared constants, command and status types for the xxhash64 stream block
// ----------------------------------------------------------------------------
`default_nettype none

package xxh_pkg;

	localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
	localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

	localparam logic [63:0] LANE_INIT0 = PR1 + PR2;
	localparam logic [63:0] LANE_INIT1 = PR2;
	localparam logic [63:0] LANE_INIT2 = 64'd0;
	localparam logic [63:0] LANE_INIT3 = 64'd0 - PR1;

	typedef enum logic [1:0] {
		K_P1,
		K_P2,
		K_P3,
		K_P5
	} mul_k_t;

	typedef enum logic [3:0] {
		MS_BUF,
		MS_LANE,
		MS_T,
		MS_H,
		MS_H_R27,
		MS_H_R23,
		MS_H_R11,
		MS_TAIL32,
		MS_TAIL8,
		MS_H_AV33,
		MS_H_AV29
	} mul_src_t;

	typedef enum logic [3:0] {
		H_HOLD,
		H_ZERO,
		H_PR5,
		H_ADD_VROT,
		H_ADD_LEN,
		H_XOR_M,
		H_M_P4,
		H_M_P3,
		H_M
	} h_op_t;

	typedef enum logic [1:0] {
		T_HOLD,
		T_ROT,
		T_LANE_ROT
	} t_op_t;

	typedef enum logic [1:0] {
		TL_HOLD,
		TL_SHR32,
		TL_SHR8
	} tl_op_t;

	typedef enum logic [1:0] {
		IN_NONE,
		IN_PUSH,
		IN_TAIL
	} in_op_t;

	typedef struct packed {
		in_op_t     in_op;
		mul_src_t   mul_src;
		mul_k_t     mul_k;
		t_op_t      t_op;
		h_op_t      h_op;
		tl_op_t     tl_op;
		logic       v_wr;
		logic [1:0] idx;
		logic       set_done;
		logic       clear;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic       done;
		logic [2:0] tcnt;
	} sts_t;

	typedef enum logic [26:0] {
		S_IDLE     = 27'h0000001,
		S_ST_MUL1  = 27'h0000002,
		S_ST_ROT   = 27'h0000004,
		S_ST_MUL2  = 27'h0000008,
		S_ST_WB    = 27'h0000010,
		S_FIN      = 27'h0000020,
		S_MG_SUM   = 27'h0000040,
		S_W_MUL1   = 27'h0000080,
		S_W_ROT    = 27'h0000100,
		S_W_MUL2   = 27'h0000200,
		S_W_XOR    = 27'h0000400,
		S_W_MUL3   = 27'h0000800,
		S_W_WB     = 27'h0001000,
		S_LEN      = 27'h0002000,
		S_T4_MUL1  = 27'h0004000,
		S_T4_XOR   = 27'h0008000,
		S_T4_MUL2  = 27'h0010000,
		S_T4_WB    = 27'h0020000,
		S_T1_MUL1  = 27'h0040000,
		S_T1_XOR   = 27'h0080000,
		S_T1_MUL2  = 27'h0100000,
		S_T1_WB    = 27'h0200000,
		S_AV_MUL1  = 27'h0400000,
		S_AV_WB1   = 27'h0800000,
		S_AV_MUL2  = 27'h1000000,
		S_AV_WB2   = 27'h2000000,
		S_OUT      = 27'h4000000
	} state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
		return (v << s) | (v >> (64 - s));
	endfunction

endpackage

`default_nettype wire

>>> src/xxh_mul.sv
// ----------------------------------------------------------------------------
// xxh_mul
// 64 x constant multiplier, low 64 bits, from three registered 32x32 products
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_mul
	import xxh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [63:0] a,
	input  wire mul_k_t      k,
	output logic      [63:0] p
);

	logic [63:0] b;
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [31:0] cross_sum;

	always_comb begin
		case (k)
			K_P1:    b = PR1;
			K_P2:    b = PR2;
			K_P3:    b = PR3;
			K_P5:    b = PR5;
			default: b = PR1;
		endcase
	end

	always_ff @(posedge clk) begin
		ll_s1 <= a[31:0] * b[31:0];
		lh_s1 <= a[31:0] * b[63:32];
		hl_s1 <= a[63:32] * b[31:0];
	end

	assign cross_sum = lh_s1 + hl_s1;
	assign p         = ll_s1 + {cross_sum, 32'd0};

endmodule

`default_nettype wire

>>> src/xxh_dp.sv
// ----------------------------------------------------------------------------
// xxh_dp
// datapath: lanes, stripe buffer, length, tail, hash register, digest
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_dp
	import xxh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  bytes_valid,
	output sts_t             sts,
	output logic      [63:0] digest
);

	logic [63:0] lane_q [4];
	logic [63:0] wbuf_q [4];
	logic [63:0] len_q;
	logic [1:0]  cnt_q;
	logic        done_q;
	logic [2:0]  tcnt_q;
	logic [63:0] h_q;
	logic [63:0] t_q;
	logic [63:0] tail_q;
	logic [63:0] digest_q;

	logic [63:0] m;
	logic [63:0] mul_a;
	logic [63:0] lane_sel;
	logic [63:0] wbuf_sel;
	logic [63:0] vrot;
	logic [63:0] tail_mask;

	assign lane_sel = lane_q[cmd.idx];
	assign wbuf_sel = wbuf_q[cmd.idx];

	always_comb begin
		case (cmd.idx)
			2'd0:    vrot = rotl64(lane_sel, 1);
			2'd1:    vrot = rotl64(lane_sel, 7);
			2'd2:    vrot = rotl64(lane_sel, 12);
			default: vrot = rotl64(lane_sel, 18);
		endcase
	end

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			tail_mask[8*j +: 8] = (3'(j) < bytes_valid[2:0]) ? 8'hFF : 8'h00;
		end
	end

	always_comb begin
		case (cmd.mul_src)
			MS_BUF:    mul_a = wbuf_sel;
			MS_LANE:   mul_a = lane_sel;
			MS_T:      mul_a = t_q;
			MS_H:      mul_a = h_q;
			MS_H_R27:  mul_a = rotl64(h_q, 27);
			MS_H_R23:  mul_a = rotl64(h_q, 23);
			MS_H_R11:  mul_a = rotl64(h_q, 11);
			MS_TAIL32: mul_a = {32'd0, tail_q[31:0]};
			MS_TAIL8:  mul_a = {56'd0, tail_q[7:0]};
			MS_H_AV33: mul_a = h_q ^ (h_q >> 33);
			MS_H_AV29: mul_a = h_q ^ (h_q >> 29);
			default:   mul_a = t_q;
		endcase
	end

	xxh_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.k   (cmd.mul_k),
		.p   (m)
	);

	// lanes and message bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q[0] <= LANE_INIT0;
			lane_q[1] <= LANE_INIT1;
			lane_q[2] <= LANE_INIT2;
			lane_q[3] <= LANE_INIT3;
			len_q     <= 64'd0;
			cnt_q     <= 2'd0;
			done_q    <= 1'b0;
			tcnt_q    <= 3'd0;
		end else if (cmd.clear) begin
			lane_q[0] <= LANE_INIT0;
			lane_q[1] <= LANE_INIT1;
			lane_q[2] <= LANE_INIT2;
			lane_q[3] <= LANE_INIT3;
			len_q     <= 64'd0;
			cnt_q     <= 2'd0;
			done_q    <= 1'b0;
			tcnt_q    <= 3'd0;
		end else begin
			if (cmd.v_wr) begin
				lane_q[cmd.idx] <= m;
			end
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
			case (cmd.in_op)
				IN_PUSH: begin
					cnt_q <= cnt_q + 2'd1;
					len_q <= len_q + 64'd8;
				end
				IN_TAIL: begin
					tcnt_q <= bytes_valid[2:0];
					len_q  <= len_q + {61'd0, bytes_valid[2:0]};
				end
				default: begin
				end
			endcase
			case (cmd.tl_op)
				TL_SHR32: tcnt_q <= tcnt_q - 3'd4;
				TL_SHR8:  tcnt_q <= tcnt_q - 3'd1;
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.in_op == IN_PUSH) begin
			wbuf_q[cnt_q] <= data_word;
		end
		case (cmd.in_op)
			IN_TAIL: tail_q <= data_word & tail_mask;
			default: begin
				case (cmd.tl_op)
					TL_SHR32: tail_q <= tail_q >> 32;
					TL_SHR8:  tail_q <= tail_q >> 8;
					default: begin
					end
				endcase
			end
		endcase
		case (cmd.t_op)
			T_ROT:      t_q <= rotl64(m, 31);
			T_LANE_ROT: t_q <= rotl64(lane_sel + m, 31);
			default: begin
			end
		endcase
		case (cmd.h_op)
			H_ZERO:     h_q <= 64'd0;
			H_PR5:      h_q <= PR5;
			H_ADD_VROT: h_q <= h_q + vrot;
			H_ADD_LEN:  h_q <= h_q + len_q;
			H_XOR_M:    h_q <= h_q ^ m;
			H_M_P4:     h_q <= m + PR4;
			H_M_P3:     h_q <= m + PR3;
			H_M:        h_q <= m;
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			digest_q <= h_q ^ (h_q >> 32);
		end
	end

	assign sts.cnt  = cnt_q;
	assign sts.done = done_q;
	assign sts.tcnt = tcnt_q;
	assign digest   = digest_q;

endmodule

`default_nettype wire

>>> src/xxh_ctrl.sv
// ----------------------------------------------------------------------------
// xxh_ctrl
// controller: sequences stripe updates, merge, tail folding and avalanche
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_ctrl
	import xxh_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	input  wire logic s_tlast,
	input  wire logic word_full,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t     state_q;
	state_t     state_d;
	state_t     tail_next;
	logic [1:0] idx_q;
	logic       idx_clr;
	logic       idx_inc;
	logic       fin_q;
	logic       merge_q;
	logic       merge_set;
	logic       merge_clr;
	logic       out_valid_q;
	logic       accept;
	logic       push;

	assign accept = s_tvalid && s_tready;
	assign push   = !s_tlast || word_full;

	always_comb begin
		if (sts.tcnt >= 3'd4) begin
			tail_next = S_T4_MUL1;
		end else if (sts.tcnt != 3'd0) begin
			tail_next = S_T1_MUL1;
		end else begin
			tail_next = S_AV_MUL1;
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.idx   = idx_q;
		state_d   = state_q;
		s_tready  = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		merge_set = 1'b0;
		merge_clr = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.in_op = push ? IN_PUSH : IN_TAIL;
					if (push && sts.cnt == 2'd3) begin
						idx_clr = 1'b1;
						state_d = S_ST_MUL1;
					end else if (s_tlast) begin
						state_d = S_FIN;
					end
				end
			end
			S_ST_MUL1: begin
				cmd.mul_src = MS_BUF;
				cmd.mul_k   = K_P2;
				state_d     = S_ST_ROT;
			end
			S_ST_ROT: begin
				cmd.t_op = T_LANE_ROT;
				state_d  = S_ST_MUL2;
			end
			S_ST_MUL2: begin
				cmd.mul_src = MS_T;
				cmd.mul_k   = K_P1;
				state_d     = S_ST_WB;
			end
			S_ST_WB: begin
				cmd.v_wr = 1'b1;
				idx_inc  = 1'b1;
				if (idx_q == 2'd3) begin
					cmd.set_done = 1'b1;
					state_d      = fin_q ? S_FIN : S_IDLE;
				end else begin
					state_d = S_ST_MUL1;
				end
			end
			S_FIN: begin
				idx_clr = 1'b1;
				if (sts.done) begin
					cmd.h_op  = H_ZERO;
					merge_set = 1'b1;
					state_d   = S_MG_SUM;
				end else begin
					cmd.h_op = H_PR5;
					state_d  = S_LEN;
				end
			end
			S_MG_SUM: begin
				cmd.h_op = H_ADD_VROT;
				idx_inc  = 1'b1;
				if (idx_q == 2'd3) begin
					state_d = S_W_MUL1;
				end
			end
			S_W_MUL1: begin
				cmd.mul_src = merge_q ? MS_LANE : MS_BUF;
				cmd.mul_k   = K_P2;
				state_d     = S_W_ROT;
			end
			S_W_ROT: begin
				cmd.t_op = T_ROT;
				state_d  = S_W_MUL2;
			end
			S_W_MUL2: begin
				cmd.mul_src = MS_T;
				cmd.mul_k   = K_P1;
				state_d     = S_W_XOR;
			end
			S_W_XOR: begin
				cmd.h_op = H_XOR_M;
				state_d  = S_W_MUL3;
			end
			S_W_MUL3: begin
				cmd.mul_src = merge_q ? MS_H : MS_H_R27;
				cmd.mul_k   = K_P1;
				state_d     = S_W_WB;
			end
			S_W_WB: begin
				cmd.h_op = H_M_P4;
				idx_inc  = 1'b1;
				if (merge_q) begin
					state_d = (idx_q == 2'd3) ? S_LEN : S_W_MUL1;
				end else begin
					state_d = (idx_q == sts.cnt - 2'd1) ? tail_next : S_W_MUL1;
				end
			end
			S_LEN: begin
				cmd.h_op  = H_ADD_LEN;
				idx_clr   = 1'b1;
				merge_clr = 1'b1;
				state_d   = (sts.cnt != 2'd0) ? S_W_MUL1 : tail_next;
			end
			S_T4_MUL1: begin
				cmd.mul_src = MS_TAIL32;
				cmd.mul_k   = K_P1;
				state_d     = S_T4_XOR;
			end
			S_T4_XOR: begin
				cmd.h_op = H_XOR_M;
				state_d  = S_T4_MUL2;
			end
			S_T4_MUL2: begin
				cmd.mul_src = MS_H_R23;
				cmd.mul_k   = K_P2;
				state_d     = S_T4_WB;
			end
			S_T4_WB: begin
				cmd.h_op  = H_M_P3;
				cmd.tl_op = TL_SHR32;
				state_d   = (sts.tcnt == 3'd4) ? S_AV_MUL1 : S_T1_MUL1;
			end
			S_T1_MUL1: begin
				cmd.mul_src = MS_TAIL8;
				cmd.mul_k   = K_P5;
				state_d     = S_T1_XOR;
			end
			S_T1_XOR: begin
				cmd.h_op = H_XOR_M;
				state_d  = S_T1_MUL2;
			end
			S_T1_MUL2: begin
				cmd.mul_src = MS_H_R11;
				cmd.mul_k   = K_P1;
				state_d     = S_T1_WB;
			end
			S_T1_WB: begin
				cmd.h_op  = H_M;
				cmd.tl_op = TL_SHR8;
				state_d   = (sts.tcnt == 3'd1) ? S_AV_MUL1 : S_T1_MUL1;
			end
			S_AV_MUL1: begin
				cmd.mul_src = MS_H_AV33;
				cmd.mul_k   = K_P2;
				state_d     = S_AV_WB1;
			end
			S_AV_WB1: begin
				cmd.h_op = H_M;
				state_d  = S_AV_MUL2;
			end
			S_AV_MUL2: begin
				cmd.mul_src = MS_H_AV29;
				cmd.mul_k   = K_P3;
				state_d     = S_AV_WB2;
			end
			S_AV_WB2: begin
				cmd.h_op = H_M;
				state_d  = S_OUT;
			end
			S_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= 2'd0;
			fin_q       <= 1'b0;
			merge_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (idx_clr) begin
				idx_q <= 2'd0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 2'd1;
			end
			if (accept) begin
				fin_q <= s_tlast;
			end
			if (merge_set) begin
				merge_q <= 1'b1;
			end else if (merge_clr) begin
				merge_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

>>> src/xxh64_stream_hash.sv
// ----------------------------------------------------------------------------
// xxh64_stream_hash
// xxhash64 (seed zero) over a stream of little-endian 64-bit message words
//
// slave side takes one word per handshake; s_tlast marks the final word of a
// message, whose byte count may be 0 to 8 (above 8 counts as 8); other words
// are always taken as eight bytes. master side gives one digest per message.
// the fourth word of a 32-byte stripe holds s_tready low while the 4 lanes
// are updated, two multiplies each. after the last word the block merges the
// lanes if a stripe was consumed, adds the length, folds each leftover full
// word, then a 4-byte chunk if 4 or more tail bytes remain, then each remaining
// single byte, then runs the avalanche and loads the output register.
// all multiplies go through one shared multiplier built from three 32x32 partial
// products with a registered stage. the digest sits in an output register; new
// words are taken while it waits. a finished digest waits in its last step,
// s_tready low, until the output register is free. reset clears lanes, counts
// and the output valid at once.
// ----------------------------------------------------------------------------
`default_nettype none

module xxh64_stream_hash
	import xxh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // data_word[63:0], bytes_valid[67:64], zero[71:68]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata    // digest[63:0]
);

	cmd_t cmd;
	sts_t sts;

	xxh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tlast   (s_tlast),
		.word_full (s_tdata[67]),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	xxh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_word   (s_tdata[63:0]),
		.bytes_valid (s_tdata[67:64]),
		.sts         (sts),
		.digest      (m_tdata)
	);

endmodule

`default_nettype wire

>>> src/xxh_chk.sv
// ----------------------------------------------------------------------------
// xxh_chk
// port-level checks for the xxhash64 stream block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module xxh_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);

	// stalled digest stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("digest dropped while stalled");

	// stalled digest keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("digest changed while stalled");

	// finalization keeps the input side closed
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("word taken right after last word");

	// a new digest appears only out of a busy cycle
	a_digest_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("digest appeared while idle");

endmodule

bind xxh64_stream_hash xxh_chk u_chk (.*);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the xxhash64 stream block against a bit-exact software hash model
//
// words go in on the slave stream, and a digest is predicted for every
// accepted last word. the predicted digests queue up in order and are
// compared with each digest taken from the master stream. a short directed
// table runs first: empty messages, partial and oversized byte counts, and a
// stripe closed by the last word or by the word before an empty last word.
// random messages follow in four phases with different idle and stall
// patterns on both sides. a watchdog ends the run if nothing moves for too
// long.
// ----------------------------------------------------------------------------

module testbench;

	localparam bit [63:0] PRIME1 = 64'h9E3779B185EBCA87;
	localparam bit [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
	localparam bit [63:0] PRIME3 = 64'h165667B19E3779F9;
	localparam bit [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
	localparam bit [63:0] PRIME5 = 64'h27D4EB2F165667C5;
	localparam bit [63:0] EMPTY_DIGEST = 64'hEF46DB3751D8E999;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_WORDS = 162;
	localparam int DIRECTED_ROWS = 21;

	typedef struct {
		bit [63:0] data;
		bit [3:0]  nb;
		bit        last;
		bit        known;
		bit [63:0] digest;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;     // data_word[63:0], bytes_valid[67:64], zero[71:68]
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;          // digest[63:0]

	bit [63:0]   lane_acc [4];
	bit [63:0]   stripe_words [4];
	int unsigned words_held;
	bit [63:0]   byte_count;
	bit          stripe_seen;

	bit [63:0]   digest_q [$];
	bit [63:0]   want_digest;
	stim_row_t   directed_rows [DIRECTED_ROWS];
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;
	int          errors = 0;

	xxh64_stream_hash DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic bit [63:0] rot64(input bit [63:0] v, input int s);
		return (v << s) | (v >> (64 - s));
	endfunction

	function automatic bit [63:0] mix_word(input bit [63:0] acc, input bit [63:0] w);
		acc = acc + w * PRIME2;
		acc = rot64(acc, 31);
		return acc * PRIME1;
	endfunction

	function automatic bit [63:0] fold_acc(input bit [63:0] h, input bit [63:0] v);
		h = h ^ mix_word(64'd0, v);
		return h * PRIME1 + PRIME4;
	endfunction

	function automatic bit [63:0] rand_word();
		bit [63:0] w;
		w = {$urandom, $urandom};
		if ($urandom_range(9) == 0) begin
			w = $urandom_range(1) ? '1 : '0;
		end
		return w;
	endfunction

	task automatic hash_clear();
		lane_acc[0] = PRIME1 + PRIME2;
		lane_acc[1] = PRIME2;
		lane_acc[2] = 64'd0;
		lane_acc[3] = 64'd0 - PRIME1;
		words_held = 0;
		byte_count = 64'd0;
		stripe_seen = 1'b0;
	endtask

	task automatic hash_absorb(input bit [63:0] w);
		stripe_words[words_held] = w;
		words_held++;
		byte_count += 64'd8;
		if (words_held == 4) begin
			for (int i = 0; i < 4; i++) begin
				lane_acc[i] = mix_word(lane_acc[i], stripe_words[i]);
			end
			words_held = 0;
			stripe_seen = 1'b1;
		end
	endtask

	// returns 1 and the digest when the word closes a message
	task automatic hash_step(input bit [63:0] w, input bit [3:0] nb, input bit last,
			output bit got, output bit [63:0] digest);
		int unsigned tail_bytes;
		bit [63:0]   tail;
		bit [63:0]   h;
		got = 1'b0;
		digest = 64'd0;
		tail_bytes = 0;
		tail = 64'd0;
		if (!last) begin
			hash_absorb(w);
			return;
		end
		if (nb >= 4'd8) begin
			hash_absorb(w);
		end else begin
			tail_bytes = {28'd0, nb};
			tail = w & ((64'd1 << (8 * nb)) - 64'd1);
			byte_count += {60'd0, nb};
		end
		if (stripe_seen) begin
			h = rot64(lane_acc[0], 1) + rot64(lane_acc[1], 7) +
				rot64(lane_acc[2], 12) + rot64(lane_acc[3], 18);
			for (int i = 0; i < 4; i++) begin
				h = fold_acc(h, lane_acc[i]);
			end
		end else begin
			h = PRIME5;
		end
		h += byte_count;
		for (int i = 0; i < words_held; i++) begin
			h ^= mix_word(64'd0, stripe_words[i]);
			h = rot64(h, 27) * PRIME1 + PRIME4;
		end
		if (tail_bytes >= 4) begin
			h ^= (tail & 64'hFFFF_FFFF) * PRIME1;
			h = rot64(h, 23) * PRIME2 + PRIME3;
			tail >>= 32;
			tail_bytes -= 4;
		end
		while (tail_bytes > 0) begin
			h ^= (tail & 64'hFF) * PRIME5;
			h = rot64(h, 11) * PRIME1;
			tail >>= 8;
			tail_bytes--;
		end
		h ^= h >> 33;
		h *= PRIME2;
		h ^= h >> 29;
		h *= PRIME3;
		h ^= h >> 32;
		digest = h;
		got = 1'b1;
		hash_clear();
	endtask

	task automatic report_error(input string what, input bit [63:0] got,
			input bit [63:0] want);
		$display("ERROR at %0t: %s, got %h want %h", $time, what, got, want);
		errors++;
	endtask

	// drives one word, waits for the handshake, then predicts
	task automatic send_word(input bit [63:0] data, input bit [3:0] nb, input bit last,
			input bit known, input bit [63:0] known_digest);
		bit        got;
		bit [63:0] digest;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, nb, data};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		hash_step(data, nb, last, got, digest);
		if (got) begin
			digest_q.push_back(known ? known_digest : digest);
		end
	endtask

	// digest checker, receiver stalls and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					report_error("digest with no message pending", m_tdata, 64'd0);
				end else begin
					want_digest = digest_q.pop_front();
					if (m_tdata !== want_digest) begin
						report_error("digest mismatch", m_tdata, want_digest);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		int        sent;
		int        nw;
		bit        noisy;
		bit [3:0]  nb;
		directed_rows = '{
			'{64'h0000_0000_0000_0000, 4'd0,  1'b1, 1'b1, EMPTY_DIGEST},
			'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b1, EMPTY_DIGEST},
			'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b0, 64'd0},
			'{64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b0, 64'd0},
			'{64'hFFFF_FFFF_FFFF_FFAB, 4'd1,  1'b1, 1'b0, 64'd0},
			'{64'h8000_0000_0000_0001, 4'd4,  1'b1, 1'b0, 64'd0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 4'd7,  1'b1, 1'b0, 64'd0},
			'{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b0, 64'd0},
			'{64'h1111_1111_1111_1111, 4'd0,  1'b0, 1'b0, 64'd0},
			'{64'h2222_2222_2222_2222, 4'd5,  1'b0, 1'b0, 64'd0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 64'd0},
			'{64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b0, 64'd0},
			'{64'hDEAD_BEEF_0BAD_F00D, 4'd8,  1'b0, 1'b0, 64'd0},
			'{64'h8000_0000_0000_0000, 4'd9,  1'b0, 1'b0, 64'd0},
			'{64'h0000_0000_0000_0001, 4'd8,  1'b0, 1'b0, 64'd0},
			'{64'h5A5A_A5A5_5A5A_A5A5, 4'd8,  1'b0, 1'b0, 64'd0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b0, 64'd0},
			'{64'h0F0F_0F0F_F0F0_F0F0, 4'd8,  1'b0, 1'b0, 64'd0},
			'{64'h7FFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b0, 64'd0},
			'{64'h3C3C_C3C3_3C3C_C3C3, 4'd8,  1'b0, 1'b0, 64'd0},
			'{64'hFEDC_BA98_7654_3210, 4'd5,  1'b1, 1'b0, 64'd0}
		};
		hash_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_word(directed_rows[r].data, directed_rows[r].nb, directed_rows[r].last,
				directed_rows[r].known, directed_rows[r].digest);
		end

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			sent = 0;
			while (sent < PHASE_WORDS) begin
				nw = ($urandom_range(99) < 85) ? $urandom_range(0, 10)
					: $urandom_range(11, 40);
				noisy = ($urandom_range(99) < 20);
				for (int k = 0; k < nw; k++) begin
					nb = noisy ? 4'($urandom_range(0, 15)) : 4'd8;
					send_word(rand_word(), nb, 1'b0, 1'b0, 64'd0);
				end
				nb = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 8))
					: 4'($urandom_range(0, 15));
				send_word(rand_word(), nb, 1'b1, 1'b0, 64'd0);
				sent += nw + 1;
			end
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (digest_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> sim.f
src/xxh_pkg.sv
src/xxh_mul.sv
src/xxh_dp.sv
src/xxh_ctrl.sv
src/xxh64_stream_hash.sv
src/xxh_chk.sv
bench/testbench.sv
